@@ design/ps2sc_pkg.sv @@
package ps2sc_pkg;

  // modifier modes
  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_SHIFT   = 2'd1,
    MODE_CONTROL = 2'd2,
    MODE_ALT     = 2'd3
  } mode_t;

  localparam int unsigned CODE_W = 8;
  localparam int unsigned CHAR_W = 8;

  // special scan codes
  localparam logic [CODE_W-1:0] SC_RELEASE = 8'hF0;
  localparam logic [CODE_W-1:0] SC_CTRL    = 8'h14;
  localparam logic [CODE_W-1:0] SC_ALT     = 8'h11;
  localparam logic [CODE_W-1:0] SC_LSHIFT  = 8'h12;
  localparam logic [CODE_W-1:0] SC_CAPS    = 8'h58;
  localparam logic [CODE_W-1:0] SC_RSHIFT  = 8'h59;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] char_code;
  } dec_result_t;

  // one row per key, packed as {alt, control, shift, normal}
  typedef logic [3:0][CHAR_W-1:0] key_row_t;

  function automatic key_row_t key_row(input logic [CODE_W-1:0] code);
    key_row_t row;
    case (code)
      8'h05: row = {8'h10, 8'h10, 8'h10, 8'h10};
      8'h06: row = {8'h11, 8'h11, 8'h11, 8'h11};
      8'h04: row = {8'h12, 8'h12, 8'h12, 8'h12};
      8'h0C: row = {8'h13, 8'h13, 8'h13, 8'h13};
      8'h03: row = {8'h14, 8'h14, 8'h14, 8'h14};
      8'h0B: row = {8'h15, 8'h15, 8'h15, 8'h15};
      8'h83: row = {8'h16, 8'h16, 8'h16, 8'h16};
      8'h0A: row = {8'h17, 8'h17, 8'h17, 8'h17};
      8'h01: row = {8'h18, 8'h18, 8'h18, 8'h18};
      8'h09: row = {8'h19, 8'h19, 8'h19, 8'h19};
      8'h78: row = {8'h1A, 8'h1A, 8'h1A, 8'h1A};
      8'h07: row = {8'h1B, 8'h1B, 8'h1B, 8'h1B};
      8'h16: row = {8'h00, 8'h00, 8'h21, 8'h31};
      8'h1E: row = {8'h00, 8'h00, 8'h40, 8'h32};
      8'h26: row = {8'h00, 8'h00, 8'h23, 8'h33};
      8'h25: row = {8'h00, 8'h00, 8'h24, 8'h34};
      8'h2E: row = {8'h00, 8'h00, 8'h25, 8'h35};
      8'h36: row = {8'h00, 8'h00, 8'h5E, 8'h36};
      8'h6C, 8'h3D: row = {8'h00, 8'h00, 8'h26, 8'h37};
      8'h75, 8'h3E: row = {8'h00, 8'h00, 8'h2A, 8'h38};
      8'h7D, 8'h46: row = {8'h00, 8'h00, 8'h28, 8'h39};
      8'h7C, 8'h45: row = {8'h00, 8'h00, 8'h29, 8'h30};
      8'h7E: row = {8'hBF, 8'h1A, 8'h3F, 8'h2A};
      8'h4E: row = {8'h00, 8'h00, 8'h5F, 8'h2D};
      8'h65: row = {8'h1B, 8'h1B, 8'h1B, 8'h1B};
      8'h15: row = {8'h71, 8'h11, 8'h51, 8'h71};
      8'h1D: row = {8'h77, 8'h17, 8'h57, 8'h77};
      8'h24: row = {8'h65, 8'h05, 8'h45, 8'h65};
      8'h2D: row = {8'h72, 8'h12, 8'h52, 8'h72};
      8'h2C: row = {8'h74, 8'h14, 8'h54, 8'h74};
      8'h35: row = {8'h79, 8'h1A, 8'h59, 8'h79};
      8'h6B, 8'h3C: row = {8'h75, 8'h15, 8'h55, 8'h75};
      8'h73, 8'h43: row = {8'h69, 8'h09, 8'h49, 8'h69};
      8'h74, 8'h44: row = {8'h6F, 8'h0F, 8'h4F, 8'h6F};
      8'h7B, 8'h4D: row = {8'h70, 8'h10, 8'h50, 8'h70};
      8'h5B: row = {8'h00, 8'h5D, 8'h7D, 8'h5D};
      8'h66: row = {8'h08, 8'h08, 8'h08, 8'h08};
      8'h0D: row = {8'h09, 8'h09, 8'h09, 8'h09};
      8'h1C: row = {8'h61, 8'h01, 8'h41, 8'h61};
      8'h1B: row = {8'h73, 8'h13, 8'h53, 8'h73};
      8'h23: row = {8'h64, 8'h04, 8'h44, 8'h64};
      8'h2B: row = {8'h66, 8'h06, 8'h46, 8'h66};
      8'h34: row = {8'h67, 8'h07, 8'h47, 8'h67};
      8'h33: row = {8'h68, 8'h08, 8'h48, 8'h68};
      8'h69, 8'h3B: row = {8'h6A, 8'h0A, 8'h4A, 8'h6A};
      8'h72, 8'h42: row = {8'h6B, 8'h0B, 8'h4B, 8'h6B};
      8'h7A, 8'h4B: row = {8'h6C, 8'h0C, 8'h4C, 8'h6C};
      8'h54: row = {8'h00, 8'h5B, 8'h7B, 8'h5B};
      8'h52: row = {8'h00, 8'h27, 8'h22, 8'h27};
      8'h1A: row = {8'h7A, 8'h19, 8'h5A, 8'h7A};
      8'h22: row = {8'h78, 8'h18, 8'h58, 8'h78};
      8'h21: row = {8'h63, 8'h03, 8'h43, 8'h63};
      8'h2A: row = {8'h76, 8'h16, 8'h56, 8'h76};
      8'h32: row = {8'h62, 8'h02, 8'h42, 8'h62};
      8'h31: row = {8'h6E, 8'h0E, 8'h4E, 8'h6E};
      8'h70, 8'h3A: row = {8'h6D, 8'h0D, 8'h4D, 8'h6D};
      8'h41: row = {8'h2C, 8'h2C, 8'h3C, 8'h2C};
      8'h49: row = {8'h2E, 8'h2E, 8'h3E, 8'h2E};
      8'h5A: row = {8'h0D, 8'h0D, 8'h0D, 8'h0D};
      8'h29: row = {8'h20, 8'h20, 8'h20, 8'h20};
      8'h63: row = {8'h75, 8'h75, 8'h55, 8'h75};
      8'h60: row = {8'h64, 8'h64, 8'h44, 8'h64};
      8'h61: row = {8'h6C, 8'h6C, 8'h4C, 8'h6C};
      8'h6A: row = {8'h72, 8'h72, 8'h52, 8'h72};
      8'h0E: row = {8'h60, 8'h60, 8'h7E, 8'h60};
      8'h79, 8'h4C: row = {8'h3B, 8'h3B, 8'h3A, 8'h3B};
      8'h4A: row = {8'h2F, 8'h2F, 8'h3F, 8'h2F};
      8'h5D: row = {8'h5C, 8'h5C, 8'h7C, 8'h5C};
      8'h55: row = {8'h3D, 8'h3D, 8'h2B, 8'h3D};
      default: row = '0;
    endcase
    return row;
  endfunction

endpackage

@@ design/ps2sc_decode.sv @@
module ps2sc_decode import ps2sc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [CODE_W-1:0] code,
  output dec_result_t       result
);

  logic     release_r, release_nxt;
  mode_t    mode_r, mode_nxt;
  key_row_t row;
  logic     is_mod;
  mode_t    mod_mode;

  always_comb begin
    is_mod   = 1'b1;
    mod_mode = MODE_NORMAL;
    case (code)
      SC_CTRL:                       mod_mode = MODE_CONTROL;
      SC_ALT:                        mod_mode = MODE_ALT;
      SC_LSHIFT, SC_CAPS, SC_RSHIFT: mod_mode = MODE_SHIFT;
      default:                       is_mod = 1'b0;
    endcase
  end

  assign row = key_row(code);

  always_comb begin
    release_nxt      = release_r;
    mode_nxt         = mode_r;
    result.valid     = 1'b0;
    result.char_code = row[mode_r];
    if (code == SC_RELEASE) begin
      release_nxt = 1'b1;
    end else if (is_mod) begin
      // a break of any modifier drops back to normal
      mode_nxt    = release_r ? MODE_NORMAL : mod_mode;
      release_nxt = 1'b0;
    end else if (release_r) begin
      release_nxt = 1'b0;
    end else begin
      result.valid = (row[mode_r] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_r <= 1'b0;
      mode_r    <= MODE_NORMAL;
    end else if (en) begin
      release_r <= release_nxt;
      mode_r    <= mode_nxt;
    end
  end

endmodule

@@ design/ps2_scancode_to_ascii.sv @@
// PS/2 scan code set 2 to ASCII decoder. Each request on the in_ channel carries one raw
// keyboard byte; a request on the out_ channel is issued only for bytes that decode to a
// nonzero character (ASCII, a control code, or a function-key code 0x10-0x1B). Release
// prefixes, modifier make/break codes, released keys and unlisted codes produce nothing
// but still update the release flag and the normal/shift/control/alt mode. The block
// takes one byte per cycle while out_ready does not stall it; each byte passes through
// the input register, the single table-decode stage and then the result register.
module ps2_scancode_to_ascii import ps2sc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_scan_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_code
);

  // input register
  logic              in_v_r;
  logic [CODE_W-1:0] code_r;
  // result register
  logic              out_v_r;
  logic [CHAR_W-1:0] char_r;

  logic        advance;
  dec_result_t dec;

  // the held byte moves on whenever the result slot is free or being drained
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  ps2sc_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .code   (code_r),
    .result (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= dec.valid;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      code_r <= in_scan_code;
    end
    if (advance && dec.valid) begin
      char_r <= dec.char_code;
    end
  end

  assign out_valid     = out_v_r;
  assign out_char_code = char_r;

endmodule

@@ test/ps2_scancode_to_ascii_tb.sv @@
`timescale 1ns / 100ps

module ps2_scancode_to_ascii_tb;
  import ps2sc_pkg::*;

  // extended-key prefixes, never listed in the key map
  localparam logic [CODE_W-1:0] SC_EXT0 = 8'hE0;
  localparam logic [CODE_W-1:0] SC_EXT1 = 8'hE1;
  // a decode of zero means no character goes out
  localparam logic [CHAR_W-1:0] NO_CHAR = 8'h00;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 2000;

  // receiver stall styles
  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_STALLS} rx_style_t;

  // one directed row: scan code, whether the char is typed in, and that char
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              typed;
    logic [CHAR_W-1:0] want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CODE_W-1:0] in_scan_code = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CHAR_W-1:0] out_char_code;

  // decoder shadow state
  bit    release_seen = 1'b0;
  mode_t cur_mode = MODE_NORMAL;

  logic [CHAR_W-1:0] char_q[$];   // characters still owed by the block
  int                err_count = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  rx_style_t         rx_style = RX_OPEN;
  int                rx_tick = 0;
  int                stall_cnt = 0;

  // directed walk: extremes, every modifier, and each corner of the release logic
  dir_row_t dir_rows [26] = '{
    '{8'h00,       1'b1, NO_CHAR},  // lowest byte right after reset, unlisted
    '{8'hFF,       1'b1, NO_CHAR},  // highest byte, unlisted
    '{SC_EXT0,     1'b1, NO_CHAR},  // extended prefix leaves state alone
    '{SC_EXT1,     1'b1, NO_CHAR},
    '{8'h1C,       1'b1, 8'h61},    // plain 'a'
    '{SC_LSHIFT,   1'b1, NO_CHAR},
    '{8'h1C,       1'b1, 8'h41},    // shifted 'A'
    '{8'h16,       1'b0, NO_CHAR},
    '{SC_RELEASE,  1'b1, NO_CHAR},
    '{SC_RELEASE,  1'b1, NO_CHAR},  // release prefix twice in a row
    '{SC_CTRL,     1'b1, NO_CHAR},  // ctrl break clears a shift mode
    '{8'h16,       1'b0, NO_CHAR},  // back to plain digit
    '{SC_CTRL,     1'b1, NO_CHAR},
    '{8'h16,       1'b1, NO_CHAR},  // digit has nothing under control
    '{8'h1C,       1'b1, 8'h01},    // ctrl-a
    '{SC_RELEASE,  1'b1, NO_CHAR},
    '{8'h2B,       1'b1, NO_CHAR},  // released ordinary key is swallowed
    '{8'h7E,       1'b0, NO_CHAR},  // still in control mode
    '{SC_ALT,      1'b1, NO_CHAR},
    '{8'h7E,       1'b1, 8'hBF},    // largest char the map gives
    '{8'h5B,       1'b1, NO_CHAR},  // bracket has nothing under alt
    '{SC_CAPS,     1'b1, NO_CHAR},
    '{8'h55,       1'b0, NO_CHAR},
    '{SC_RELEASE,  1'b1, NO_CHAR},
    '{SC_RSHIFT,   1'b1, NO_CHAR},
    '{8'h78,       1'b0, NO_CHAR}   // function key
  };

  ps2_scancode_to_ascii u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_scan_code (in_scan_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code)
  );

  always #10 clk = ~clk;

  // key map, one word per key laid out as {normal, shift, control, alt}
  function automatic logic [CHAR_W-1:0] key_char(input logic [CODE_W-1:0] code,
                                                 input mode_t m);
    logic [31:0] row;
    case (code)
      8'h05: row = 32'h10101010;
      8'h06: row = 32'h11111111;
      8'h04: row = 32'h12121212;
      8'h0C: row = 32'h13131313;
      8'h03: row = 32'h14141414;
      8'h0B: row = 32'h15151515;
      8'h83: row = 32'h16161616;
      8'h0A: row = 32'h17171717;
      8'h01: row = 32'h18181818;
      8'h09: row = 32'h19191919;
      8'h78: row = 32'h1A1A1A1A;
      8'h07, 8'h65: row = 32'h1B1B1B1B;
      8'h16: row = 32'h31210000;
      8'h1E: row = 32'h32400000;
      8'h26: row = 32'h33230000;
      8'h25: row = 32'h34240000;
      8'h2E: row = 32'h35250000;
      8'h36: row = 32'h365E0000;
      8'h6C, 8'h3D: row = 32'h37260000;
      8'h75, 8'h3E: row = 32'h382A0000;
      8'h7D, 8'h46: row = 32'h39280000;
      8'h7C, 8'h45: row = 32'h30290000;
      8'h7E: row = 32'h2A3F1ABF;
      8'h4E: row = 32'h2D5F0000;
      8'h15: row = 32'h71511171;
      8'h1D: row = 32'h77571777;
      8'h24: row = 32'h65450565;
      8'h2D: row = 32'h72521272;
      8'h2C: row = 32'h74541474;
      8'h35: row = 32'h79591A79;
      8'h6B, 8'h3C: row = 32'h75551575;
      8'h73, 8'h43: row = 32'h69490969;
      8'h74, 8'h44: row = 32'h6F4F0F6F;
      8'h7B, 8'h4D: row = 32'h70501070;
      8'h5B: row = 32'h5D7D5D00;
      8'h66: row = 32'h08080808;
      8'h0D: row = 32'h09090909;
      8'h1C: row = 32'h61410161;
      8'h1B: row = 32'h73531373;
      8'h23: row = 32'h64440464;
      8'h2B: row = 32'h66460666;
      8'h34: row = 32'h67470767;
      8'h33: row = 32'h68480868;
      8'h69, 8'h3B: row = 32'h6A4A0A6A;
      8'h72, 8'h42: row = 32'h6B4B0B6B;
      8'h7A, 8'h4B: row = 32'h6C4C0C6C;
      8'h54: row = 32'h5B7B5B00;
      8'h52: row = 32'h27222700;
      8'h1A: row = 32'h7A5A197A;
      8'h22: row = 32'h78581878;
      8'h21: row = 32'h63430363;
      8'h2A: row = 32'h76561676;
      8'h32: row = 32'h62420262;
      8'h31: row = 32'h6E4E0E6E;
      8'h70, 8'h3A: row = 32'h6D4D0D6D;
      8'h41: row = 32'h2C3C2C2C;
      8'h49: row = 32'h2E3E2E2E;
      8'h5A: row = 32'h0D0D0D0D;
      8'h29: row = 32'h20202020;
      8'h63: row = 32'h75557575;
      8'h60: row = 32'h64446464;
      8'h61: row = 32'h6C4C6C6C;
      8'h6A: row = 32'h72527272;
      8'h0E: row = 32'h607E6060;
      8'h79, 8'h4C: row = 32'h3B3A3B3B;
      8'h4A: row = 32'h2F3F2F2F;
      8'h5D: row = 32'h5C7C5C5C;
      8'h55: row = 32'h3D2B3D3D;
      default: row = '0;
    endcase
    return row[(3 - int'(m)) * 8 +: 8];
  endfunction

  // make sets the mode, a break after the prefix drops back to normal
  function automatic void modifier_key(input mode_t m);
    if (!release_seen) begin
      cur_mode = m;
    end else begin
      cur_mode = MODE_NORMAL;
      release_seen = 1'b0;
    end
  endfunction

  // advance the shadow decoder by one byte, return the char it owes (zero for none)
  function automatic logic [CHAR_W-1:0] decode_byte(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    ch = NO_CHAR;
    case (code)
      SC_RELEASE: release_seen = 1'b1;
      SC_CTRL:    modifier_key(MODE_CONTROL);
      SC_ALT:     modifier_key(MODE_ALT);
      SC_LSHIFT, SC_CAPS, SC_RSHIFT: modifier_key(MODE_SHIFT);
      default: begin
        if (release_seen) begin
          release_seen = 1'b0;
        end else begin
          ch = key_char(code, cur_mode);
        end
      end
    endcase
    return ch;
  endfunction

  // any make code that has a character in normal mode; modifiers have none
  function automatic logic [CODE_W-1:0] pick_key();
    logic [CODE_W-1:0] code;
    do begin
      code = CODE_W'($urandom_range(0, 255));
    end while (key_char(code, MODE_NORMAL) == NO_CHAR);
    return code;
  endfunction

  function automatic logic [CODE_W-1:0] pick_modifier();
    case ($urandom_range(0, 4))
      0:       return SC_CTRL;
      1:       return SC_ALT;
      2:       return SC_LSHIFT;
      3:       return SC_CAPS;
      default: return SC_RSHIFT;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // one request on the input side; bursts of random length with random gaps between
  task automatic put_byte(input logic [CODE_W-1:0] code, input bit typed,
                          input logic [CHAR_W-1:0] want);
    int                gap;
    logic [CHAR_W-1:0] ch;
    if (burst_left == 0) begin
      // now and then a long stretch with no idling
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_scan_code <= code;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    ch = decode_byte(code);
    if (typed) ch = want;
    if (ch != NO_CHAR) char_q.push_back(ch);
  endtask

  // hold the sender off until the block has delivered everything it owes
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // receiver: drives out_ready in a stall style that is picked anew at random
  always @(posedge clk) begin
    rx_tick = rx_tick + 1;
    if (rx_tick % 256 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
    case (rx_style)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_COMB:  out_ready <= (rx_tick % 7) > 2;
      default: begin
        // occasional long stalls
        if (stall_cnt > 0) begin
          stall_cnt = stall_cnt - 1;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_cnt = $urandom_range(1, 20);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // result check against the oldest owed character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (char_q.size() == 0) begin
        report_mismatch($sformatf("char %02h with nothing owed", out_char_code));
      end else begin
        if (out_char_code !== char_q[0])
          report_mismatch($sformatf("char_code got %02h want %02h",
                                    out_char_code, char_q[0]));
        void'(char_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int               rand_count;
    int               n;
    bit               paused_mid;
    logic [CODE_W-1:0] key;
    rand_count = 0;
    paused_mid = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) put_byte(dir_rows[i].code, dir_rows[i].typed, dir_rows[i].want);
    drain_pause();

    // random typing: mostly well-formed key strokes, some noise and broken sequences
    while (rand_count < RANDOM_ITEMS) begin
      if (!paused_mid && rand_count >= RANDOM_ITEMS / 2) begin
        drain_pause();
        paused_mid = 1'b1;
      end
      n = $urandom_range(0, 99);
      if (n < 45) begin
        // key stroke, often with its break
        key = pick_key();
        put_byte(key, 1'b0, NO_CHAR);
        rand_count++;
        if ($urandom_range(0, 1)) begin
          put_byte(SC_RELEASE, 1'b0, NO_CHAR);
          put_byte(key, 1'b0, NO_CHAR);
          rand_count += 2;
        end
      end else if (n < 60) begin
        put_byte(pick_modifier(), 1'b0, NO_CHAR);
        rand_count++;
      end else if (n < 72) begin
        // modifier break, not always of the held one
        put_byte(SC_RELEASE, 1'b0, NO_CHAR);
        put_byte(pick_modifier(), 1'b0, NO_CHAR);
        rand_count += 2;
      end else if (n < 80) begin
        // extended key, make or break
        put_byte(SC_EXT0, 1'b0, NO_CHAR);
        rand_count++;
        if ($urandom_range(0, 1)) begin
          put_byte(SC_RELEASE, 1'b0, NO_CHAR);
          rand_count++;
        end
        put_byte(pick_key(), 1'b0, NO_CHAR);
        rand_count++;
      end else if (n < 88) begin
        // typematic repeat
        key = pick_key();
        repeat ($urandom_range(2, 6)) begin
          put_byte(key, 1'b0, NO_CHAR);
          rand_count++;
        end
      end else if (n < 96) begin
        // raw noise, any byte
        put_byte(CODE_W'($urandom_range(0, 255)), 1'b0, NO_CHAR);
        rand_count++;
      end else begin
        // broken release: doubled prefix then any byte
        put_byte(SC_RELEASE, 1'b0, NO_CHAR);
        put_byte(SC_RELEASE, 1'b0, NO_CHAR);
        put_byte(CODE_W'($urandom_range(0, 255)), 1'b0, NO_CHAR);
        rand_count += 3;
      end
    end

    in_valid <= 1'b0;
    while (char_q.size() != 0) @(posedge clk);
    // let any stray output come out of the pipe before the verdict
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
